/* rtl/ssb_pkg.sv */
`timescale 1ns / 1ps
package ssb_pkg;

    localparam int DEFAULT_MAX_PERIODS = 64;
    localparam int CFG_W     = 7;
    localparam int IDX_W     = 2;
    localparam int FACT_W    = 45;
    localparam int NUM_W     = 61;
    localparam int BASE_W    = 33;
    localparam int SPREAD_W  = 31;
    localparam int CHUNK_W   = 15;
    localparam int PROD_W    = 2 * FACT_W;

    localparam logic [SPREAD_W-1:0] ONE_Q30    = SPREAD_W'(1) << 30;
    localparam logic [SPREAD_W-1:0] TOL_Q30    = SPREAD_W'(10737);
    localparam logic [FACT_W-1:0]   FACTOR_CAP = FACT_W'(1) << 44;
    localparam logic [31:0]         PRICE_MAX  = 32'hFFFF_FFFF;
    localparam logic [6:0]          FACE_VALUE = 7'd100;

    localparam logic [IDX_W-1:0] REG_COUPON  = 2'd0;
    localparam logic [IDX_W-1:0] REG_PERIODS = 2'd1;

    localparam logic [1:0] STAT_CONV  = 2'd0;
    localparam logic [1:0] STAT_EXACT = 2'd1;
    localparam logic [1:0] STAT_NOBR  = 2'd2;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] zero_rate;
        logic [31:0]        target_price;
    } in_t;

    typedef struct packed {
        logic [SPREAD_W-1:0] spread;
        logic [1:0]          status;
    } out_t;

endpackage

/* rtl/static_spread_bisection.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    in_word  (mode, zero_rate, target_price)
// out       output     out_valid/out_ready  out_word (spread, status)
// cfg       input      cfg_we               cfg_index, cfg_data
//
// A solve runs up to about 17 bisection rounds; each round prices three points with the
// shared bit-serial divider and the shared multiplier.
// The rate memory needs no clearing pass; reset clears the sequencer, bounds, load index,
// output valid flag and configuration registers.
// in_ready is low for the whole solve and while a finished result waits for the
// output register to be freed by the receiver.
module static_spread_bisection
    import ssb_pkg::*;
#(
    parameter int MAX_PERIODS = DEFAULT_MAX_PERIODS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_t              in_word,
    output logic             out_valid,
    input  logic             out_ready,
    output out_t             out_word,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int AW     = (MAX_PERIODS > 1) ? $clog2(MAX_PERIODS) : 1;
    localparam int CW     = $clog2(MAX_PERIODS + 1);
    localparam int SUM_W  = FACT_W + CFG_W + CW + 1;
    localparam int CMP_W  = (CW > CFG_W) ? CW : CFG_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PERIODS);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_ROUND = 11'b000_0000_0010,
        S_READ  = 11'b000_0000_0100,
        S_BASE  = 11'b000_0000_1000,
        S_DIV   = 11'b000_0001_0000,
        S_POW   = 11'b000_0010_0000,
        S_MUL   = 11'b000_0100_0000,
        S_ACC   = 11'b000_1000_0000,
        S_FIN   = 11'b001_0000_0000,
        S_DEC   = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0]          mem [MAX_PERIODS];
    logic [31:0]          rd_reg;

    logic [CFG_W-1:0]     coupon_reg, periods_reg;
    logic [CW-1:0]        load_idx_reg;
    logic [CW-1:0]        n_reg;
    logic [31:0]          target_reg;
    logic [SPREAD_W-1:0]  lower_reg, upper_reg;
    logic [1:0]           pt_reg;
    logic [CW-1:0]        i_reg, k_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic                 sat_reg;
    logic [BASE_W-1:0]    base_reg;
    logic [NUM_W-1:0]     num_reg, q_reg;
    logic [BASE_W:0]      rem_reg;
    logic [5:0]           cnt_reg;
    logic [FACT_W-1:0]    r_reg, d_reg;
    logic [PROD_W-1:0]    acc_reg;
    logic [1:0]           step_reg;
    logic [2:0]           eq_reg, gt_reg;
    logic [SPREAD_W-1:0]  res_reg;
    logic [1:0]           stat_reg;
    logic                 out_valid_reg;
    out_t                 out_word_reg;

    logic                 accept;
    logic [SPREAD_W-1:0]  mid, s_cur;
    logic [31:0]          mid_sum;
    logic signed [BASE_W:0] base_s;
    logic [BASE_W:0]      rem_shift;
    logic                 rem_ge;
    logic [NUM_W-1:0]     q_next;
    logic [CHUNK_W-1:0]   chunk;
    logic [FACT_W+CHUNK_W-1:0] partial;
    logic [PROD_W-1:0]    acc_next;
    logic [PROD_W-31:0]   prod_q30;
    logic [FACT_W-1:0]    mul_res;
    logic [SUM_W:0]       sum_fin;
    logic [SUM_W-12:0]    price_wide;
    logic [31:0]          price;
    logic [CMP_W-1:0]     per_ext, max_ext;
    logic [CW-1:0]        n_clamp;
    logic                 done_write;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    assign mid_sum = {1'b0, upper_reg} + {1'b0, lower_reg};
    assign mid     = mid_sum[SPREAD_W:1];

    always_comb
    begin
        unique case (pt_reg)
            2'd0:    s_cur = mid;
            2'd1:    s_cur = upper_reg;
            default: s_cur = lower_reg;
        endcase
    end

    assign base_s = (BASE_W+1)'(ONE_Q30) + (BASE_W+1)'(s_cur)
                  + (BASE_W+1)'($signed(rd_reg));

    // One restoring division step per cycle.
    assign rem_shift = {rem_reg[BASE_W-1:0], num_reg[NUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, base_reg});
    assign q_next    = {q_reg[NUM_W-2:0], rem_ge};

    // The multiplier takes one 15-bit slice of r per cycle.
    assign chunk    = CHUNK_W'(r_reg >> (CHUNK_W * step_reg));
    assign partial  = d_reg * chunk;
    assign acc_next = acc_reg + (PROD_W'(partial) << (CHUNK_W * step_reg));
    assign prod_q30 = acc_next[PROD_W-1:30];
    assign mul_res  = (prod_q30 > (PROD_W-30)'(FACTOR_CAP)) ? FACTOR_CAP
                                                              : prod_q30[FACT_W-1:0];

    assign sum_fin    = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(FACE_VALUE * d_reg)
                      + (SUM_W+1)'(2048);
    assign price_wide = sum_fin[SUM_W:12];
    always_comb
    begin
        if (sat_reg || price_wide > (SUM_W-11)'(PRICE_MAX))
            price = PRICE_MAX;
        else
            price = price_wide[31:0];
    end

    assign per_ext = CMP_W'(periods_reg);
    assign max_ext = CMP_W'(MAX_CNT);
    always_comb
    begin
        if (per_ext == '0)
            n_clamp = CW'(1);
        else if (per_ext > max_ext)
            n_clamp = MAX_CNT;
        else
            n_clamp = per_ext[CW-1:0];
    end

    assign done_write = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk)
    begin
        if (accept && !in_word.mode && load_idx_reg < MAX_CNT)
            mem[load_idx_reg[AW-1:0]] <= in_word.zero_rate;
        rd_reg <= mem[i_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coupon_reg  <= '0;
            periods_reg <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_COUPON)
                coupon_reg <= cfg_data;
            else if (cfg_index == REG_PERIODS)
                periods_reg <= cfg_data;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept && in_word.mode) state_next = S_ROUND;
            S_ROUND: state_next = (upper_reg - lower_reg <= TOL_Q30) ? S_DONE : S_READ;
            S_READ:  state_next = S_BASE;
            S_BASE:  state_next = (base_s <= 0) ? S_FIN : S_DIV;
            S_DIV:   if (cnt_reg == 6'(NUM_W - 1)) state_next = S_POW;
            S_POW:   state_next = (k_reg == i_reg) ? S_ACC : S_MUL;
            S_MUL:   if (step_reg == 2'd2) state_next = S_POW;
            S_ACC:   state_next = (i_reg + CW'(1) == n_reg) ? S_FIN : S_READ;
            S_FIN:   state_next = (pt_reg == 2'd2) ? S_DEC : S_READ;
            S_DEC:
            begin
                if (eq_reg != '0 || (gt_reg[0] == gt_reg[1] && gt_reg[0] == gt_reg[2]))
                    state_next = S_DONE;
                else
                    state_next = S_ROUND;
            end
            S_DONE:  if (done_write) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            load_idx_reg  <= '0;
            lower_reg     <= '0;
            upper_reg     <= ONE_Q30;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (done_write)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && !in_word.mode && load_idx_reg < MAX_CNT)
                        load_idx_reg <= load_idx_reg + CW'(1);
                    else if (accept && in_word.mode)
                    begin
                        load_idx_reg <= '0;
                        lower_reg    <= '0;
                        upper_reg    <= ONE_Q30;
                    end
                end
                S_DEC:
                begin
                    if (eq_reg == '0 && gt_reg[0] != gt_reg[1])
                        lower_reg <= mid;
                    else if (eq_reg == '0 && gt_reg[0] != gt_reg[2])
                        upper_reg <= mid;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                target_reg <= in_word.target_price;
                n_reg      <= n_clamp;
            end
            S_ROUND:
            begin
                res_reg  <= lower_reg;
                stat_reg <= STAT_CONV;
                pt_reg   <= 2'd0;
                i_reg    <= '0;
                sum_reg  <= '0;
                sat_reg  <= 1'b0;
            end
            S_BASE:
            begin
                if (base_s <= 0)
                    sat_reg <= 1'b1;
                base_reg <= base_s[BASE_W-1:0];
                num_reg  <= (NUM_W'(1) << 60) + NUM_W'(base_s[BASE_W-1:1]);
                rem_reg  <= '0;
                q_reg    <= '0;
                cnt_reg  <= '0;
            end
            S_DIV:
            begin
                rem_reg <= rem_ge ? (rem_shift - {1'b0, base_reg}) : rem_shift;
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                q_reg   <= q_next;
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(NUM_W - 1))
                begin
                    r_reg <= (q_next > NUM_W'(FACTOR_CAP)) ? FACTOR_CAP
                                                             : q_next[FACT_W-1:0];
                    d_reg <= (q_next > NUM_W'(FACTOR_CAP)) ? FACTOR_CAP
                                                             : q_next[FACT_W-1:0];
                    k_reg <= '0;
                end
            end
            S_POW:
            begin
                acc_reg  <= '0;
                step_reg <= 2'd0;
            end
            S_MUL:
            begin
                acc_reg  <= acc_next;
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    d_reg <= mul_res;
                    k_reg <= k_reg + CW'(1);
                end
            end
            S_ACC:
            begin
                sum_reg <= sum_reg + SUM_W'(coupon_reg * d_reg);
                i_reg   <= i_reg + CW'(1);
            end
            S_FIN:
            begin
                eq_reg[pt_reg] <= (price == target_reg);
                gt_reg[pt_reg] <= (price > target_reg);
                pt_reg  <= pt_reg + 2'd1;
                i_reg   <= '0;
                sum_reg <= '0;
                sat_reg <= 1'b0;
            end
            S_DEC:
            begin
                priority if (eq_reg[0])
                begin
                    res_reg  <= mid;
                    stat_reg <= STAT_EXACT;
                end
                else if (eq_reg[1])
                begin
                    res_reg  <= upper_reg;
                    stat_reg <= STAT_EXACT;
                end
                else if (eq_reg[2])
                begin
                    res_reg  <= lower_reg;
                    stat_reg <= STAT_EXACT;
                end
                else
                begin
                    res_reg  <= lower_reg;
                    stat_reg <= STAT_NOBR;
                end
            end
            S_DONE:
            begin
                if (done_write)
                begin
                    out_word_reg.spread <= res_reg;
                    out_word_reg.status <= stat_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        lower_reg <= upper_reg)
        else $error("bisection bounds crossed");

    a_upper_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        upper_reg <= ONE_Q30)
        else $error("upper bound above one");

    a_load_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        load_idx_reg <= MAX_CNT)
        else $error("load index beyond store depth");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (out_word_reg.status == STAT_CONV
            || out_word_reg.status == STAT_EXACT || out_word_reg.status == STAT_NOBR))
        else $error("result word with unknown status");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import ssb_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    in_t              in_word;
    logic             out_valid;
    logic             out_ready;
    out_t             out_word;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    static_spread_bisection uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    localparam int NPER = DEFAULT_MAX_PERIODS;

    // Shadow of the block's state.
    logic signed [31:0] curve[NPER];
    int                 fill_idx;
    int                 coupon_q;
    int                 periods_q;

    out_t spread_due[$];
    int   mismatches;
    int   solves_seen;
    int   loads_sent;
    bit   quiet;
    bit   long_hold;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(40_000_000);
        $display("timeout waiting for the block");
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [63:0] q30_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> 30;
        if (p > 128'(FACTOR_CAP))
            return 64'(FACTOR_CAP);
        return p[63:0];
    endfunction

    function automatic logic [63:0] bond_price(longint s, int n);
        logic [63:0] total;
        logic [63:0] disc;
        logic [63:0] recip;
        longint      base;
        total = 0;
        disc = 0;
        for (int i = 0; i < n; i++)
        begin
            base = (longint'(1) << 30) + s + longint'(curve[i]);
            if (base <= 0)
                return 64'(PRICE_MAX);
            recip = ((64'd1 << 60) + (64'(base) >> 1)) / 64'(base);
            if (recip > 64'(FACTOR_CAP))
                recip = 64'(FACTOR_CAP);
            disc = recip;
            for (int k = 0; k < i; k++)
                disc = q30_mul(disc, recip);
            total += 64'(coupon_q) * disc;
        end
        total += 64'd100 * disc;
        total = (total + 64'd2048) >> 12;
        return (total > 64'(PRICE_MAX)) ? 64'(PRICE_MAX) : total;
    endfunction

    function automatic int sgn(longint v);
        return (v < 0) ? -1 : ((v > 0) ? 1 : 0);
    endfunction

    function automatic out_t solve_spread(logic [31:0] target);
        out_t   r;
        int     n;
        longint lo, hi, mid, dm, du, dl;
        n = (periods_q == 0) ? 1 : ((periods_q > NPER) ? NPER : periods_q);
        lo = 0;
        hi = longint'(1) << 30;
        forever
        begin
            if (hi - lo <= longint'(TOL_Q30))
            begin
                r.spread = SPREAD_W'(lo);
                r.status = STAT_CONV;
                return r;
            end
            mid = (hi + lo) / 2;
            dm = longint'(bond_price(mid, n)) - longint'(target);
            du = longint'(bond_price(hi, n)) - longint'(target);
            dl = longint'(bond_price(lo, n)) - longint'(target);
            r.status = STAT_EXACT;
            if (dm == 0)
            begin
                r.spread = SPREAD_W'(mid);
                return r;
            end
            if (du == 0)
            begin
                r.spread = SPREAD_W'(hi);
                return r;
            end
            if (dl == 0)
            begin
                r.spread = SPREAD_W'(lo);
                return r;
            end
            if (sgn(dm) != sgn(du))
                lo = mid;
            else if (sgn(dm) != sgn(dl))
                hi = mid;
            else
            begin
                r.spread = SPREAD_W'(lo);
                r.status = STAT_NOBR;
                return r;
            end
        end
    endfunction

    // Sender: the word is accepted at the edge where valid and ready are both high.
    task automatic send_word(in_t w, bit typed, out_t want);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        do
            @(posedge clk);
        while (!in_ready);
        if (w.mode == 1'b0)
        begin
            loads_sent++;
            if (fill_idx < NPER)
            begin
                curve[fill_idx] = w.zero_rate;
                fill_idx++;
            end
        end
        else
        begin
            fill_idx = 0;
            spread_due.push_back(typed ? want : solve_spread(w.target_price));
        end
    endtask

    // Registers change only once the block has drained.
    task automatic drain();
        in_valid <= 1'b0;
        while (spread_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, int val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(val);
        @(posedge clk);
        if (idx == REG_COUPON)
            coupon_q = val;
        else
            periods_q = val;
    endtask

    task automatic set_bond(int c, int n);
        drain();
        write_reg(REG_COUPON, c);
        write_reg(REG_PERIODS, n);
        cfg_we <= 1'b0;
    endtask

    function automatic in_t load_word(logic [31:0] rate);
        in_t w;
        w.mode = 1'b0;
        w.zero_rate = rate;
        w.target_price = $urandom;
        return w;
    endfunction

    function automatic in_t solve_word(logic [31:0] price);
        in_t w;
        w.mode = 1'b1;
        w.zero_rate = $urandom;
        w.target_price = price;
        return w;
    endfunction

    // Receiver with random stalls and one long hold-off that outlasts two solves.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                long_hold = 1'b0;
                stall = 50000;
            end
            else
                stall = quiet ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid && !long_hold);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (spread_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: spread %0d status %0d",
                             out_word.spread, out_word.status);
            end
            else
            begin
                out_t want;
                want = spread_due.pop_front();
                solves_seen++;
                if (want.spread !== out_word.spread || want.status !== out_word.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: spread exp %0d got %0d, status exp %0d got %0d",
                                 want.spread, out_word.spread, want.status, out_word.status);
                end
            end
        end
    end

    typedef struct {
        int          c;
        int          n;
        logic        mode;
        logic [31:0] value;
        bit          typed;
        out_t        want;
    } row_t;

    row_t rows[16];

    initial
    begin
        int np;
        int extra;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        fill_idx = 0;
        coupon_q = 0;
        periods_q = 1;
        mismatches = 0;
        solves_seen = 0;
        loads_sent = 0;
        quiet = 1'b0;
        long_hold = 1'b0;
        for (int i = 0; i < NPER; i++)
            curve[i] = '0;

        // A rate of minus two keeps every base at or below zero, so all prices saturate.
        rows = '{
            '{0,   1,  1'b0, 32'h8000_0000, 1'b0, '0},
            '{-1, -1,  1'b1, 32'hFFFF_FFFF, 1'b1, '{31'h2000_0000, STAT_EXACT}},
            '{-1, -1,  1'b1, 32'h0000_0000, 1'b1, '{31'd0, STAT_NOBR}},
            '{5,   2,  1'b0, 32'h7FFF_FFFF, 1'b0, '0},
            '{-1, -1,  1'b0, 32'h0000_0000, 1'b0, '0},
            '{-1, -1,  1'b1, 32'h0190_0000, 1'b0, '0},
            '{-1, -1,  1'b1, 32'h0001_0000, 1'b0, '0},
            '{127, 0,  1'b0, 32'h0400_0000, 1'b0, '0},
            '{-1, -1,  1'b1, 32'h01A0_0000, 1'b0, '0},
            '{-1, -1,  1'b1, 32'hFFFF_FFFF, 1'b0, '0},
            '{4,   3,  1'b0, 32'h0200_0000, 1'b0, '0},
            '{-1, -1,  1'b0, 32'h0300_0000, 1'b0, '0},
            '{-1, -1,  1'b0, 32'hFC00_0000, 1'b0, '0},
            '{-1, -1,  1'b1, 32'h017C_0000, 1'b0, '0},
            '{-1, -1,  1'b1, 32'h01B8_0000, 1'b0, '0},
            '{100, 3,  1'b1, 32'h0400_0000, 1'b0, '0}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].c >= 0)
                set_bond(rows[i].c, rows[i].n);
            send_word(rows[i].mode ? solve_word(rows[i].value) : load_word(rows[i].value),
                      rows[i].typed, rows[i].want);
        end

        // Random curves: mostly short bonds with plausible rates and prices.
        for (int cv = 0; cv < 14; cv++)
        begin
            np = $urandom_range(0, 4);
            set_bond($urandom_range(0, 127), np);
            quiet = (cv % 7 == 3);
            if (cv == 5)
                long_hold = 1'b1;
            extra = $urandom_range(0, 2);
            for (int k = 0; k < ((np == 0) ? 1 : np) + extra; k++)
                send_word(load_word(($urandom_range(0, 9) == 0) ? $urandom
                                    : 32'($urandom_range(0, 32'h0800_0000)) - 32'h0100_0000),
                          1'b0, '0);
            // Three solves under the long hold-off fill the output and stall the input.
            for (int k = (cv == 5) ? 3 : $urandom_range(1, 3); k > 0; k--)
                send_word(solve_word(($urandom_range(0, 5) == 0) ? $urandom
                                     : 32'($urandom_range(32'h00C8_0000, 32'h0280_0000))),
                          1'b0, '0);
        end
        quiet = 1'b0;

        // Full store: the last load is dropped. The count above the limit is clamped,
        // and a zero target gives no sign change after the first round.
        set_bond(100, 127);
        for (int k = 0; k <= NPER; k++)
            send_word(load_word(32'($urandom_range(0, 32'h0400_0000))), 1'b0, '0);
        send_word(solve_word(32'h0), 1'b0, '0);

        drain();
        repeat (100) @(posedge clk);
        $display("covered %0d rate loads and %0d solved spreads over several bond setups",
                 loads_sent, solves_seen);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0 && spread_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
